FILE: src/mpbm_pkg.sv
// Shared types and constants for the multi-pattern byte matcher.
// No dependencies; imported by multi_pattern_byte_matcher_unit.
package mpbm_pkg;

  localparam int DEF_MAX_NODES     = 256;
  localparam int DEF_MAX_PATTERNS  = 32;
  localparam int DEF_ALPHABET_SIZE = 256;

  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] FOLD_OFFSET = 8'd32;
  localparam logic [5:0] COUNT_SAT   = 6'd63;
  localparam int         MASK_OUT_W  = 32;

  typedef enum logic [1:0] {
    ACT_PATTERN = 2'd0,
    ACT_BUILD   = 2'd1,
    ACT_TEXT    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_TOO_MANY  = 3'd2,
    STAT_NOT_BUILT = 3'd3,
    STAT_BUILT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CK_RESET,
    CK_CLEAR,
    CK_ALLOC
  } clr_kind_t;

endpackage

FILE: src/multi_pattern_byte_matcher_unit.sv
// Multi-pattern byte matcher: trie insert, breadth-first build, text scan.
// Depends on mpbm_pkg. Holds the transition, output-mask, fail-link and queue memories.
//
// Channel   Dir  Signals                                  Contents
// s_axis    in   tvalid tready tdata[7:0] tuser[1:0] tlast data_byte / action / last
// m_axis    out  tvalid tready tdata[47:0]               status, any_match, count, mask
// cfg       in   cfg_wr_en cfg_wr_data                    case_fold
//
// One shared sequencer drives memories with one read and one write port and registered reads.
// A text byte passes the read, node and mask states; the last one adds a popcount pass and
// the emit state. A pattern byte passes the read, check and end states (only the end state
// when skipped), plus a row clear when a node is allocated; the last byte adds the mask
// read, mask write and emit states (only emit on an error status). Build reads and checks
// the root row, then per queued node runs pop, fail and mask steps and a pass over its row,
// and ends in pop and emit. Reset and clear run a pass over the root row; no item is
// taken meanwhile. A held result does not block input until the next result.
module multi_pattern_byte_matcher_unit
  import mpbm_pkg::*;
#(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int MAX_PATTERNS  = DEF_MAX_PATTERNS,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [2:0] status, [3] any_match,
                                      // [9:4] match_count, [41:10] match_mask
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int MW  = MAX_PATTERNS;
  localparam int PCW = $clog2(MAX_PATTERNS + 1);
  localparam int TAW = NW + SW;
  localparam logic [NW:0]     NODE_LIM = (NW + 1)'(MAX_NODES);
  localparam logic [PCW-1:0]  PAT_LIM  = PCW'(MAX_PATTERNS);
  localparam logic [SW-1:0]   SYM_LAST = SW'(ALPHABET_SIZE - 1);

  function automatic logic [256*SW-1:0] sym_tab_f();
    logic [256*SW-1:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      r[i*SW +: SW] = SW'(i % ALPHABET_SIZE);
    end
    return r;
  endfunction

  localparam logic [256*SW-1:0] SYM_TAB = sym_tab_f();

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_P_READ, S_P_CHECK, S_P_END, S_P_MREAD, S_P_MWRITE,
    S_B_ROOT_RD, S_B_ROOT_CHK, S_B_POP, S_B_U, S_B_F, S_B_MF, S_B_MU,
    S_B_TU, S_B_TF, S_B_ACT,
    S_T_RD, S_T_NODE, S_T_MASK, S_T_CNT,
    S_EMIT
  } state_t;

  state_t          state;
  clr_kind_t       clr_kind;
  logic            case_fold;
  action_t         act_in;
  logic [7:0]      folded;
  logic [SW-1:0]   sym_in;
  logic [SW-1:0]   sym_reg;
  logic            last_reg;
  logic [SW-1:0]   sym_idx;
  logic [NW-1:0]   clr_row;
  logic [NW:0]     node_count;
  logic [PCW-1:0]  pattern_count;
  logic [NW-1:0]   insert_node;
  logic [NW-1:0]   match_node;
  logic [MW-1:0]   seen_mask;
  logic            built_flag;
  logic            pattern_error;
  logic [NW:0]     head;
  logic [NW:0]     tail;
  logic [NW-1:0]   u_reg;
  logic [NW-1:0]   f_reg;
  logic [NW-1:0]   v_reg;
  logic [MW-1:0]   mf_reg;
  logic [MW-1:0]   pop_sh;
  logic [6:0]      pop_cnt;
  status_t         pend_status;
  logic            pend_any;
  logic [5:0]      pend_cnt;
  logic [31:0]     pend_mask;
  logic [63:0]     seen_ext;
  logic            in_xfer;

  // memory ports
  logic [NW-1:0]   trans_mem [2**TAW];
  logic [MW-1:0]   mask_mem  [2**NW];
  logic [NW-1:0]   fail_mem  [2**NW];
  logic [NW-1:0]   queue_mem [2**NW];
  logic [TAW-1:0]  t_raddr, t_waddr;
  logic [NW-1:0]   t_rdata, t_wdata;
  logic            t_we;
  logic [NW-1:0]   m_raddr, m_waddr;
  logic [MW-1:0]   m_rdata, m_wdata;
  logic            m_we;
  logic [NW-1:0]   f_raddr, f_waddr;
  logic [NW-1:0]   f_rdata, f_wdata;
  logic            f_we;
  logic [NW-1:0]   q_raddr, q_waddr;
  logic [NW-1:0]   q_rdata, q_wdata;
  logic            q_we;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign act_in        = action_t'(s_axis_tuser);
  assign folded = (case_fold && s_axis_tdata >= CH_UPPER_A && s_axis_tdata <= CH_UPPER_Z)
                ? s_axis_tdata + FOLD_OFFSET : s_axis_tdata;
  assign sym_in   = SYM_TAB[int'(folded)*SW +: SW];
  assign seen_ext = 64'(seen_mask);

  always_comb begin
    t_raddr = '0; t_waddr = '0; t_wdata = '0; t_we = 1'b0;
    m_raddr = '0; m_waddr = '0; m_wdata = '0; m_we = 1'b0;
    f_raddr = '0; f_waddr = '0; f_wdata = '0; f_we = 1'b0;
    q_raddr = '0; q_waddr = '0; q_wdata = '0; q_we = 1'b0;
    case (state)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = {clr_row, sym_idx};
        if (sym_idx == '0) begin
          m_we    = 1'b1;
          m_waddr = clr_row;
          f_we    = 1'b1;
          f_waddr = clr_row;
        end
      end
      S_P_READ: t_raddr = {insert_node, sym_reg};
      S_P_CHECK: begin
        if (t_rdata == '0 && node_count < NODE_LIM) begin
          t_we    = 1'b1;
          t_waddr = {insert_node, sym_reg};
          t_wdata = node_count[NW-1:0];
        end
      end
      S_P_MREAD: m_raddr = insert_node;
      S_P_MWRITE: begin
        m_we    = 1'b1;
        m_waddr = insert_node;
        m_wdata = m_rdata | (MW'(1) << pattern_count);
      end
      S_B_ROOT_RD: t_raddr = {NW'(0), sym_idx};
      S_B_ROOT_CHK: begin
        if (t_rdata != '0 && tail < NODE_LIM) begin
          f_we    = 1'b1;
          f_waddr = t_rdata;
          q_we    = 1'b1;
          q_waddr = tail[NW-1:0];
          q_wdata = t_rdata;
        end
      end
      S_B_POP: q_raddr = head[NW-1:0];
      S_B_U:   f_raddr = q_rdata;
      S_B_F:   m_raddr = f_rdata;
      S_B_MF:  m_raddr = u_reg;
      S_B_MU: begin
        m_we    = 1'b1;
        m_waddr = u_reg;
        m_wdata = m_rdata | mf_reg;
      end
      S_B_TU: t_raddr = {u_reg, sym_idx};
      S_B_TF: t_raddr = {f_reg, sym_idx};
      S_B_ACT: begin
        if (v_reg != '0) begin
          f_we    = 1'b1;
          f_waddr = v_reg;
          f_wdata = t_rdata;
          if (tail < NODE_LIM) begin
            q_we    = 1'b1;
            q_waddr = tail[NW-1:0];
            q_wdata = v_reg;
          end
        end else begin
          // missing edge: copy the fail target's transition
          t_we    = 1'b1;
          t_waddr = {u_reg, sym_idx};
          t_wdata = t_rdata;
        end
      end
      S_T_RD:   t_raddr = {match_node, sym_reg};
      S_T_NODE: m_raddr = t_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) trans_mem[t_waddr] <= t_wdata;
    t_rdata <= trans_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (m_we) mask_mem[m_waddr] <= m_wdata;
    m_rdata <= mask_mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_waddr] <= f_wdata;
    f_rdata <= fail_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_kind      <= CK_RESET;
      clr_row       <= '0;
      sym_idx       <= '0;
      case_fold     <= 1'b1;
      node_count    <= (NW + 1)'(1);
      pattern_count <= '0;
      insert_node   <= '0;
      match_node    <= '0;
      seen_mask     <= '0;
      built_flag    <= 1'b0;
      pattern_error <= 1'b0;
      head          <= '0;
      tail          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) case_fold <= cfg_wr_data;

      if (state == S_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {6'd0, pend_mask, pend_cnt, pend_any, pend_status};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          if (sym_idx == SYM_LAST) begin
            case (clr_kind)
              CK_CLEAR: state <= S_EMIT;
              CK_ALLOC: state <= S_P_END;
              default:  state <= S_IDLE;
            endcase
          end else begin
            sym_idx <= sym_idx + SW'(1);
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            sym_reg     <= sym_in;
            last_reg    <= s_axis_tlast;
            pend_status <= STAT_OK;
            pend_any    <= 1'b0;
            pend_cnt    <= '0;
            pend_mask   <= '0;
            case (act_in)
              ACT_PATTERN: begin
                if (!built_flag && !pattern_error && pattern_count < PAT_LIM) begin
                  state <= S_P_READ;
                end else begin
                  state <= S_P_END;
                end
              end
              ACT_BUILD: begin
                if (built_flag) begin
                  pend_status <= STAT_BUILT;
                  state       <= S_EMIT;
                end else begin
                  sym_idx <= '0;
                  head    <= '0;
                  tail    <= '0;
                  state   <= S_B_ROOT_RD;
                end
              end
              ACT_TEXT: begin
                if (built_flag) begin
                  state <= S_T_RD;
                end else if (s_axis_tlast) begin
                  pend_status <= STAT_NOT_BUILT;
                  state       <= S_EMIT;
                end
              end
              default: begin
                node_count    <= (NW + 1)'(1);
                pattern_count <= '0;
                insert_node   <= '0;
                match_node    <= '0;
                seen_mask     <= '0;
                built_flag    <= 1'b0;
                pattern_error <= 1'b0;
                clr_row       <= '0;
                sym_idx       <= '0;
                clr_kind      <= CK_CLEAR;
                state         <= S_CLR;
              end
            endcase
          end
        end
        S_P_READ: state <= S_P_CHECK;
        S_P_CHECK: begin
          if (t_rdata == '0) begin
            if (node_count >= NODE_LIM) begin
              pattern_error <= 1'b1;
              state         <= S_P_END;
            end else begin
              // new node: clear its row before use
              insert_node <= node_count[NW-1:0];
              clr_row     <= node_count[NW-1:0];
              node_count  <= node_count + (NW + 1)'(1);
              sym_idx     <= '0;
              clr_kind    <= CK_ALLOC;
              state       <= S_CLR;
            end
          end else begin
            insert_node <= t_rdata;
            state       <= S_P_END;
          end
        end
        S_P_END: begin
          if (!last_reg) begin
            state <= S_IDLE;
          end else if (!built_flag && !pattern_error && pattern_count < PAT_LIM) begin
            state <= S_P_MREAD;
          end else begin
            if (built_flag) begin
              pend_status <= STAT_BUILT;
            end else if (pattern_error) begin
              pend_status <= STAT_FULL;
            end else begin
              pend_status <= STAT_TOO_MANY;
            end
            insert_node   <= '0;
            pattern_error <= 1'b0;
            state         <= S_EMIT;
          end
        end
        S_P_MREAD: state <= S_P_MWRITE;
        S_P_MWRITE: begin
          pattern_count <= pattern_count + PCW'(1);
          insert_node   <= '0;
          pattern_error <= 1'b0;
          state         <= S_EMIT;
        end
        S_B_ROOT_RD: state <= S_B_ROOT_CHK;
        S_B_ROOT_CHK: begin
          if (t_rdata != '0 && tail < NODE_LIM) tail <= tail + (NW + 1)'(1);
          if (sym_idx == SYM_LAST) begin
            state <= S_B_POP;
          end else begin
            sym_idx <= sym_idx + SW'(1);
            state   <= S_B_ROOT_RD;
          end
        end
        S_B_POP: begin
          if (head < tail) begin
            head  <= head + (NW + 1)'(1);
            state <= S_B_U;
          end else begin
            built_flag <= 1'b1;
            state      <= S_EMIT;
          end
        end
        S_B_U: begin
          u_reg <= q_rdata;
          state <= S_B_F;
        end
        S_B_F: begin
          f_reg <= f_rdata;
          state <= S_B_MF;
        end
        S_B_MF: begin
          mf_reg <= m_rdata;
          state  <= S_B_MU;
        end
        S_B_MU: begin
          sym_idx <= '0;
          state   <= S_B_TU;
        end
        S_B_TU: state <= S_B_TF;
        S_B_TF: begin
          v_reg <= t_rdata;
          state <= S_B_ACT;
        end
        S_B_ACT: begin
          if (v_reg != '0 && tail < NODE_LIM) tail <= tail + (NW + 1)'(1);
          if (sym_idx == SYM_LAST) begin
            state <= S_B_POP;
          end else begin
            sym_idx <= sym_idx + SW'(1);
            state   <= S_B_TU;
          end
        end
        S_T_RD: state <= S_T_NODE;
        S_T_NODE: begin
          match_node <= t_rdata;
          state      <= S_T_MASK;
        end
        S_T_MASK: begin
          seen_mask <= seen_mask | m_rdata;
          if (last_reg) begin
            pop_sh  <= seen_mask | m_rdata;
            pop_cnt <= '0;
            state   <= S_T_CNT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_T_CNT: begin
          // count one mask bit per cycle
          if (pop_sh == '0) begin
            pend_any    <= (seen_mask != '0);
            pend_cnt    <= (pop_cnt > 7'(COUNT_SAT)) ? COUNT_SAT : pop_cnt[5:0];
            pend_mask   <= seen_ext[MASK_OUT_W-1:0];
            seen_mask   <= '0;
            match_node  <= '0;
            state       <= S_EMIT;
          end else begin
            pop_cnt <= pop_cnt + 7'(pop_sh[0]);
            pop_sh  <= pop_sh >> 1;
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_node_count_range: assert property (@(posedge clk) disable iff (rst)
    node_count != '0 && node_count <= NODE_LIM)
    else $error("node count out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail && tail <= NODE_LIM)
    else $error("bfs queue head passed tail");

  a_any_vs_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[9:4] != 6'd0)))
    else $error("any_match disagrees with match_count");

  a_error_no_match: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2:0] != STAT_OK) |-> (m_axis_tdata[41:3] == '0))
    else $error("match fields set on an error result");
`endif

endmodule
